[sv/peak_hold_db_level_meter_top_macros.svh]
// assertion macros shared by the peak hold level meter files
`ifndef PEAK_HOLD_DB_LEVEL_METER_TOP_MACROS_SVH
`define PEAK_HOLD_DB_LEVEL_METER_TOP_MACROS_SVH

// same-cycle implication
`define PHDB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PHDB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/phdb_pkg.sv]
// types and constants of the peak hold dB level meter
package phdb_pkg;

    localparam int CHANNELS  = 2;
    localparam int SQ_STEPS  = 16;
    localparam int LOG_W     = 5 + SQ_STEPS;
    localparam int DB_STAGES = SQ_STEPS + 5;

    typedef logic signed [15:0] t_db;
    typedef logic               t_chan;
    typedef logic [30:0]        t_level;
    typedef logic [1:0]         t_cfg_idx;
    typedef logic [8:0]         t_cfg_data;

    typedef struct packed {
        logic [7:0] bar_width;
        logic [7:0] pixels_per_db;
        logic [8:0] decay_gain;
    } t_cfg;

    localparam t_cfg_idx CFG_BAR_WIDTH     = 2'd0;
    localparam t_cfg_idx CFG_PIXELS_PER_DB = 2'd1;
    localparam t_cfg_idx CFG_DECAY_GAIN    = 2'd2;

    localparam t_cfg CFG_RESET = '{bar_width: 8'd100, pixels_per_db: 8'd24,
                                   decay_gain: 9'd282};

    // log2 of the full-scale reference 0x7fffff00 in q5.16
    localparam logic [LOG_W-1:0] REF_LOG2    = 21'h1E_FFFF;
    localparam logic [18:0]      DB_PER_LOG2 = 19'd394566;

    localparam t_db         DB_ZERO_INPUT = -16'sd30720;
    localparam t_db         DB_RESET      = -16'sd25600;
    localparam t_db         DB_UNSTICK    = -16'sd128;
    localparam logic [16:0] DB_MIN_MAG    = 17'd32768;

    localparam t_chan CHAN_MAX = 1'(CHANNELS - 1);

endpackage

[sv/phdb_if.sv]
// request and result channels of the peak hold dB level meter
interface phdb_in_if;
    logic              valid;
    logic              ready;
    phdb_pkg::t_chan   channel;
    phdb_pkg::t_level  peak_level;
    modport source (output valid, channel, peak_level, input ready);
    modport sink (input valid, channel, peak_level, output ready);
endinterface

interface phdb_out_if;
    logic              valid;
    logic              ready;
    phdb_pkg::t_chan   out_channel;
    logic [7:0]        bar_length;
    logic              clear_peak;
    phdb_pkg::t_db     held_db;
    modport source (output valid, out_channel, bar_length, clear_peak, held_db, input ready);
    modport sink (input valid, out_channel, bar_length, clear_peak, held_db, output ready);
endinterface

interface phdb_db_if;
    logic              valid;
    logic              ready;
    phdb_pkg::t_chan   channel;
    phdb_pkg::t_db     db;
    modport source (output valid, channel, db, input ready);
    modport sink (input valid, channel, db, output ready);
endinterface

[sv/peak_hold_db_level_meter_top.sv]
// peak hold dB level meter top level
//
// i_in carries one request per channel update: the channel number and the
// captured peak magnitude in q31. o_res returns one result per request in
// request order: the channel, the bar length in pixels, the clear_peak flag
// and the held peak before decay in q8.8 dBFS.
// a request is taken at a rising edge with valid and ready high; the same
// holds for a result. the configuration port writes bar_width, pixels_per_db
// and decay_gain by index; the user must do so only while no request is in
// flight, as the block does not enforce it. one request is taken every cycle
// unless the receiver stalls. the level conversion is a 21-stage pipeline:
// three stages find the leading one and normalize, sixteen each do one
// 31x31 squaring for one log2 fraction bit, and two scale to dB. the held
// peaks are read, compared, decayed and written back as the result register
// loads, so back-to-back requests on one channel see each update.
// when the receiver stalls, the result register keeps its result and the
// conversion pipeline holds once its last stage is full; until then requests
// still enter the empty stages.
// synchronous reset sets the registers to their defaults, both held peaks to
// -100 dB and clears all valid flags; ready is low during reset.
`include "peak_hold_db_level_meter_top_macros.svh"

module peak_hold_db_level_meter_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    phdb_in_if.sink              i_in,
    phdb_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  phdb_pkg::t_cfg_idx   i_cfg_idx,
    input  phdb_pkg::t_cfg_data  i_cfg_data
);

    phdb_db_if w_db ();

    phdb_pkg::t_cfg         r_cfg;
    phdb_pkg::t_db          r_peak [phdb_pkg::CHANNELS];

    logic                   w_take;
    phdb_pkg::t_chan        w_idx;
    phdb_pkg::t_db          w_old;
    logic                   w_new;
    phdb_pkg::t_db          w_held;
    logic signed [24:0]     w_prod;
    logic signed [25:0]     w_total;
    logic [7:0]             w_bar_pre;
    logic [7:0]             w_bar;
    logic [16:0]            w_mag;
    logic [25:0]            w_scaled;
    logic [16:0]            w_dmag;
    logic [16:0]            w_dneg;
    phdb_pkg::t_db          w_dec;

    logic                   r_ov;
    phdb_pkg::t_chan        r_o_ch;
    logic [7:0]             r_o_bar;
    logic                   r_o_clr;
    phdb_pkg::t_db          r_o_held;

    phdb_db_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_db    (w_db)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= phdb_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                phdb_pkg::CFG_BAR_WIDTH:     r_cfg.bar_width     <= i_cfg_data[7:0];
                phdb_pkg::CFG_PIXELS_PER_DB: r_cfg.pixels_per_db <= i_cfg_data[7:0];
                phdb_pkg::CFG_DECAY_GAIN:    r_cfg.decay_gain    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_db.ready = !r_ov || o_res.ready;
    assign w_take     = w_db.valid && w_db.ready;

    // peak compare
    assign w_idx  = (w_db.channel > phdb_pkg::CHAN_MAX) ? phdb_pkg::CHAN_MAX : w_db.channel;
    assign w_old  = r_peak[w_idx];
    assign w_new  = w_db.db > w_old;
    assign w_held = w_new ? w_db.db : w_old;

    // bar length in q.12
    assign w_prod    = $signed({1'b0, r_cfg.pixels_per_db}) * w_held;
    assign w_total   = $signed({6'b0, r_cfg.bar_width, 12'b0}) + 26'(w_prod);
    assign w_bar_pre = (w_total < 26'sd4096) ? 8'd1 : w_total[19:12];
    assign w_bar     = (w_bar_pre > r_cfg.bar_width) ? r_cfg.bar_width : w_bar_pre;

    // decay
    assign w_mag    = 17'(0) - 17'(w_held);
    assign w_scaled = w_mag * r_cfg.decay_gain;
    assign w_dmag   = (w_scaled[25:8] > 18'(phdb_pkg::DB_MIN_MAG)) ? phdb_pkg::DB_MIN_MAG
                                                                    : w_scaled[24:8];
    assign w_dneg   = 17'(0) - w_dmag;
    assign w_dec    = (w_held == '0) ? phdb_pkg::DB_UNSTICK : w_dneg[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            for (int c = 0; c < phdb_pkg::CHANNELS; c++) r_peak[c] <= phdb_pkg::DB_RESET;
        end else begin
            if (w_take) begin
                r_ov          <= 1'b1;
                r_peak[w_idx] <= w_dec;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_o_ch   <= w_db.channel;
            r_o_bar  <= w_bar;
            r_o_clr  <= w_new;
            r_o_held <= w_held;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.out_channel = r_o_ch;
    assign o_res.bar_length  = r_o_bar;
    assign o_res.clear_peak  = r_o_clr;
    assign o_res.held_db     = r_o_held;

    `PHDB_ASSERT_NEXT(a_take_shows, i_clk, i_rst_n, w_take, o_res.valid, "update without result")
    `PHDB_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, r_ov && !o_res.ready, r_ov, "result dropped")
    `PHDB_ASSERT_NOW(a_peak_nonpos, i_clk, i_rst_n, w_take, w_old <= 16'sd0, "peak above 0 dB")

endmodule

[sv/phdb_db_conv.sv]
// pipelined q31 magnitude to q8.8 dBFS conversion
`include "peak_hold_db_level_meter_top_macros.svh"

module phdb_db_conv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    phdb_in_if.sink     i_in,
    phdb_db_if.source   o_db
);

    localparam int NSTG = phdb_pkg::DB_STAGES;
    localparam int SQ   = phdb_pkg::SQ_STEPS;
    localparam int LW   = phdb_pkg::LOG_W;

    logic                 w_en;
    logic                 r_v  [NSTG];
    phdb_pkg::t_chan      r_ch [NSTG];

    phdb_pkg::t_level     r_x0;
    phdb_pkg::t_level     r_x1;
    logic [4:0]           r_e1;
    logic                 r_z1;
    logic [4:0]           n_e;

    logic [30:0]          r_m  [SQ+1];
    logic [4:0]           r_e  [SQ+1];
    logic                 r_z  [SQ+1];
    logic [SQ-1:0]        r_fr [SQ+1];

    logic [LW-1:0]        w_n;
    logic [39:0]          w_mprod;
    logic [39:0]          r_prod;
    logic                 r_ref0;
    logic                 r_zm;

    logic [40:0]          w_rsum;
    logic [16:0]          w_mag;
    logic [16:0]          w_mneg;
    phdb_pkg::t_db        r_db;

    assign w_en       = !r_v[NSTG-1] || o_db.ready;
    assign i_in.ready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_in.valid;
            for (int k = 1; k < NSTG; k++) r_v[k] <= r_v[k-1];
        end
    end

    // leading one position
    always_comb begin
        n_e = '0;
        for (int k = 0; k < 31; k++) begin
            if (r_x0[k]) n_e = 5'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ch[0] <= i_in.channel;
            for (int k = 1; k < NSTG; k++) r_ch[k] <= r_ch[k-1];
            r_x0    <= i_in.peak_level;
            r_x1    <= r_x0;
            r_e1    <= n_e;
            r_z1    <= (r_x0 == '0);
            r_m[0]  <= r_x1 << (5'd30 - r_e1);
            r_e[0]  <= r_e1;
            r_z[0]  <= r_z1;
            r_fr[0] <= '0;
        end
    end

    // one fraction bit per squaring stage
    for (genvar j = 1; j <= SQ; j++) begin : g_sq
        logic [61:0] w_p;
        logic [31:0] w_q;
        logic [30:0] w_mn;

        assign w_p  = r_m[j-1] * r_m[j-1];
        assign w_q  = w_p[61:30];
        assign w_mn = w_q[31] ? w_q[31:1] : w_q[30:0];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_m[j]  <= w_mn;
                r_e[j]  <= r_e[j-1];
                r_z[j]  <= r_z[j-1];
                r_fr[j] <= {r_fr[j-1][SQ-2:0], w_q[31]};
            end
        end
    end

    assign w_n     = phdb_pkg::REF_LOG2 - {r_e[SQ], r_fr[SQ]};
    assign w_mprod = w_n * phdb_pkg::DB_PER_LOG2;

    assign w_rsum = {1'b0, r_prod} + 41'h80_0000;
    assign w_mag  = (w_rsum[40:24] > phdb_pkg::DB_MIN_MAG) ? phdb_pkg::DB_MIN_MAG
                                                           : w_rsum[40:24];
    assign w_mneg = 17'(0) - w_mag;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= w_mprod;
            r_ref0 <= (w_n == '0);
            r_zm   <= r_z[SQ];
            if (r_zm) begin
                r_db <= phdb_pkg::DB_ZERO_INPUT;
            end else if (r_ref0) begin
                r_db <= '0;
            end else begin
                r_db <= w_mneg[15:0];
            end
        end
    end

    assign o_db.valid   = r_v[NSTG-1];
    assign o_db.channel = r_ch[NSTG-1];
    assign o_db.db      = r_db;

    `PHDB_ASSERT_NOW(a_norm_in, i_clk, i_rst_n, r_v[2] && !r_z[0], r_m[0][30], "not normalized")
    `PHDB_ASSERT_NOW(a_norm_sq, i_clk, i_rst_n, r_v[2+SQ] && !r_z[SQ], r_m[SQ][30], "bad mantissa")
    `PHDB_ASSERT_NOW(a_db_nonpos, i_clk, i_rst_n, r_v[NSTG-1], r_db <= 16'sd0, "positive level")

endmodule
